FILE: rtl/tojb_pkg.sv
// Shared types and constants for the timestamp-ordered jitter buffer.
`timescale 1ns / 1ps
package tojb_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = 5;
  localparam int TS_W       = 48;
  localparam int TAG_W      = 16;
  localparam int ENTRY_W    = TS_W + TAG_W;
  localparam int LAT_W      = 32;
  localparam int DL_W       = TS_W + 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLOSE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CANCEL  = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 1'b0,
    REG_MAX_LATENCY = 1'b1
  } reg_e;

endpackage

FILE: rtl/timestamp_ordered_jitter_buffer.sv
// Top level of the timestamp-ordered jitter buffer: sequencer and entry RAM.
//
// Usage: one command beat is taken at a rising edge with start high and busy
// low; func_i selects push, pop or close, with the timestamp, tag and watermark
// fields sampled at that edge. busy rises on the next cycle and stays high
// while the sequencer works. Exactly one result beat follows each command:
// done_o is high for one cycle with status, drop, release and occupancy on
// the result ports; the receiver cannot stall it. busy is already low in that
// cycle, so the next command may be given there.
// Close, no-op, refused pushes and pops with nothing held or no watermark
// finish from the dispatch state; other pops first compare the head entry.
// A push walks the held entries from the tail one per cycle through the
// RAM's single read port and single write port, moving each later entry up
// by one slot; an overflow first tests the head in its own state. Entries
// live in a circular RAM addressed from a head pointer.
// Configuration writes take effect at once; the user must make them only while idle (the block does not enforce it).
// Reset empties the buffer, reopens it, forgets the last released stamp,
// sets capacity to DEPTH and latency to zero; the RAM needs no clearing.
`timescale 1ns / 1ps
module timestamp_ordered_jitter_buffer
  import tojb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func_i,
  input  logic [TS_W-1:0]       pts_i,
  input  logic                  pts_valid_i,
  input  logic [TAG_W-1:0]      tag_i,
  input  logic [TS_W-1:0]       watermark_i,
  input  logic                  watermark_valid_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic                  dropped_o,
  output logic                  ready_res_o,
  output logic [TS_W-1:0]       out_pts_o,
  output logic [TAG_W-1:0]      out_tag_o,
  output logic [CNT_W-1:0]      occupancy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_OVF,
    S_INS_START,
    S_INS,
    S_HEAD,
    S_POP
  } state_e;

  state_e state_q, state_d;

  func_e                   func_q;
  logic [TS_W-1:0]         pts_q;
  logic                    ptsv_q;
  logic [TAG_W-1:0]        tag_q;
  logic [TS_W-1:0]         wm_q;
  logic                    wmv_q;

  logic [CNT_W-1:0]        cap_q;
  logic [LAT_W-1:0]        lat_q;
  logic [IDX_W-1:0]        hd_q, hd_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        j_q, j_d;
  logic [TS_W-1:0]         last_q, last_d;
  logic                    last_v_q, last_v_d;
  logic                    closed_q, closed_d;
  logic signed [DL_W-1:0]  dl_q, dl_d;
  logic                    drop_q, drop_d;

  logic                    done_q, done_d;
  status_e                 status_q, status_d;
  logic                    dropped_q, dropped_d;
  logic                    ready_q, ready_d;
  logic [TS_W-1:0]         opts_q, opts_d;
  logic [TAG_W-1:0]        otag_q, otag_d;
  logic [CNT_W-1:0]        occ_q, occ_d;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
  logic [TS_W-1:0]         rd_stamp;
  logic [TAG_W-1:0]        rd_tag;
  logic [CNT_W-1:0]        eff_cap;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    fin;
  status_e                 fin_st;
  logic                    fin_drp, fin_rdy;
  logic [TS_W-1:0]         fin_pts;
  logic [TAG_W-1:0]        fin_tag;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                            input logic [IDX_W-1:0] l);
    logic [IDX_W:0] sum;
    sum = {1'b0, hd} + {1'b0, l};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  tojb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_stamp = ram_rdata[ENTRY_W-1:TAG_W];
  assign rd_tag   = ram_rdata[TAG_W-1:0];
  assign busy     = (state_q != S_IDLE);
  assign cnt_m1   = cnt_q - CNT_W'(1);

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_q > CNT_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = cap_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    hd_d      = hd_q;
    cnt_d     = cnt_q;
    j_d       = j_q;
    last_d    = last_q;
    last_v_d  = last_v_q;
    closed_d  = closed_q;
    dl_d      = dl_q;
    drop_d    = drop_q;
    done_d    = 1'b0;
    status_d  = status_q;
    dropped_d = dropped_q;
    ready_d   = ready_q;
    opts_d    = opts_q;
    otag_d    = otag_q;
    occ_d     = occ_q;
    ram_we    = 1'b0;
    ram_waddr = phys(hd_q, j_q + IDX_W'(1));
    ram_wdata = {pts_q, tag_q};
    ram_raddr = hd_q;
    fin       = 1'b0;
    fin_st    = ST_OK;
    fin_drp   = 1'b0;
    fin_rdy   = 1'b0;
    fin_pts   = '0;
    fin_tag   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        drop_d = 1'b0;
        unique case (func_q)
          FUNC_PUSH: begin
            if (closed_q) begin
              fin    = 1'b1;
              fin_st = ST_CANCEL;
            end else if (!ptsv_q) begin
              fin    = 1'b1;
              fin_st = ST_INVALID;
            end else if (last_v_q && ($signed(pts_q) <= $signed(last_q))) begin
              fin     = 1'b1;
              fin_drp = 1'b1;
            end else if (cnt_q >= eff_cap) begin
              state_d = S_OVF;
            end else begin
              state_d = S_INS_START;
            end
          end
          FUNC_POP: begin
            if ((cnt_q != '0) && wmv_q) begin
              dl_d    = {{2{wm_q[TS_W-1]}}, wm_q} - $signed({{(DL_W-LAT_W){1'b0}}, lat_q});
              state_d = S_POP;
            end else begin
              fin = 1'b1;
            end
          end
          FUNC_CLOSE: begin
            closed_d = 1'b1;
            cnt_d    = '0;
            fin      = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_OVF: begin
        if ($signed(rd_stamp) > $signed(pts_q)) begin
          fin     = 1'b1;
          fin_drp = 1'b1;
        end else begin
          hd_d    = phys(hd_q, IDX_W'(1));
          cnt_d   = cnt_m1;
          drop_d  = 1'b1;
          state_d = S_INS_START;
        end
      end
      S_INS_START: begin
        if (cnt_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = hd_q;
          cnt_d     = CNT_W'(1);
          fin       = 1'b1;
          fin_drp   = drop_q;
        end else begin
          j_d       = cnt_m1[IDX_W-1:0];
          ram_raddr = phys(hd_q, cnt_m1[IDX_W-1:0]);
          state_d   = S_INS;
        end
      end
      S_INS: begin
        ram_we = 1'b1;
        if ($signed(rd_stamp) > $signed(pts_q)) begin
          ram_wdata = ram_rdata;
          if (j_q == '0) begin
            state_d = S_HEAD;
          end else begin
            j_d       = j_q - IDX_W'(1);
            ram_raddr = phys(hd_q, j_q - IDX_W'(1));
          end
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          fin     = 1'b1;
          fin_drp = drop_q;
        end
      end
      S_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = hd_q;
        cnt_d     = cnt_q + CNT_W'(1);
        fin       = 1'b1;
        fin_drp   = drop_q;
      end
      S_POP: begin
        if ($signed({{2{rd_stamp[TS_W-1]}}, rd_stamp}) <= dl_q) begin
          fin_rdy  = 1'b1;
          fin_pts  = rd_stamp;
          fin_tag  = rd_tag;
          last_d   = rd_stamp;
          last_v_d = 1'b1;
          hd_d     = phys(hd_q, IDX_W'(1));
          cnt_d    = cnt_m1;
        end
        fin = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d   = S_IDLE;
      done_d    = 1'b1;
      status_d  = fin_st;
      dropped_d = fin_drp;
      ready_d   = fin_rdy;
      opts_d    = fin_pts;
      otag_d    = fin_tag;
      occ_d     = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cap_q     <= CAP_RESET;
      lat_q     <= '0;
      hd_q      <= '0;
      cnt_q     <= '0;
      j_q       <= '0;
      last_q    <= '0;
      last_v_q  <= 1'b0;
      closed_q  <= 1'b0;
      drop_q    <= 1'b0;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      dropped_q <= 1'b0;
      ready_q   <= 1'b0;
      occ_q     <= '0;
    end else begin
      state_q   <= state_d;
      hd_q      <= hd_d;
      cnt_q     <= cnt_d;
      j_q       <= j_d;
      last_q    <= last_d;
      last_v_q  <= last_v_d;
      closed_q  <= closed_d;
      drop_q    <= drop_d;
      done_q    <= done_d;
      status_q  <= status_d;
      dropped_q <= dropped_d;
      ready_q   <= ready_d;
      occ_q     <= occ_d;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_CAPACITY:    cap_q <= cfg_data_i[CNT_W-1:0];
          REG_MAX_LATENCY: lat_q <= cfg_data_i[LAT_W-1:0];
          default:         cap_q <= cap_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    opts_q <= opts_d;
    otag_q <= otag_d;
    dl_q   <= dl_d;
    if (state_q == S_IDLE && start) begin
      func_q <= func_e'(func_i);
      pts_q  <= pts_i;
      ptsv_q <= pts_valid_i;
      tag_q  <= tag_i;
      wm_q   <= watermark_i;
      wmv_q  <= watermark_valid_i;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign dropped_o   = dropped_q;
  assign ready_res_o = ready_q;
  assign out_pts_o   = opts_q;
  assign out_tag_o   = otag_q;
  assign occupancy_o = occ_q;

endmodule

FILE: rtl/tojb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tojb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/tojb_checker.sv
// Port-level checks for the jitter buffer, bound to the top level.
`timescale 1ns / 1ps
module tojb_checker
  import tojb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [1:0]       status_o,
  input logic             dropped_o,
  input logic             ready_res_o,
  input logic [CNT_W-1:0] occupancy_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted command did not start work");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result beat without preceding work");

  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> !dropped_o && !ready_res_o)
    else $error("refused command reported drop or release");

  a_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ready_res_o |-> !dropped_o && (occupancy_o < CNT_W'(DEPTH)))
    else $error("release beat inconsistent");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> occupancy_o <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

endmodule

bind timestamp_ordered_jitter_buffer tojb_checker u_tojb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .status_o    (status_o),
  .dropped_o   (dropped_o),
  .ready_res_o (ready_res_o),
  .occupancy_o (occupancy_o)
);
